// ===== hdl/mt_pkg.sv =====
// Package for the MT19937 generator: state machine type, command and status
// structs, and the fixed constants of the algorithm. No dependencies.
`timescale 1ns / 1ps

package mt_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int IDX_W        = $clog2(STATE_WORDS + 1);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] POS_END  = IDX_W'(STATE_WORDS);

    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] DEFAULT_SEED = 32'd5489;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;

    typedef enum logic [3:0] {
        S_INIT,
        S_SEED_MUL,
        S_SEED_ADD,
        S_IDLE,
        S_TW_PRIME,
        S_TW_READ,
        S_TW_WRITE,
        S_DRAW_READ,
        S_DRAW_LOAD
    } t_state;

    typedef struct packed {
        logic seed_start;
        logic use_default;
        logic seed_mul;
        logic seed_add;
        logic tw_prime;
        logic tw_read;
        logic tw_write;
        logic draw_read;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_last;
        logic pos_end;
    } t_dp_status;

endpackage

// ===== hdl/mt_in_if.sv =====
// Input channel of the MT19937 generator: valid/ready handshake with the
// operation code and the seed. No dependencies.
`timescale 1ns / 1ps

interface mt_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] seed_value;

    modport source (output valid, output operation, output seed_value, input ready);
    modport sink (input valid, input operation, input seed_value, output ready);
endinterface

// ===== hdl/mt_out_if.sv =====
// Output channel of the MT19937 generator: valid/ready handshake with the
// tempered random word. No dependencies.
`timescale 1ns / 1ps

interface mt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink (input valid, input random_word, output ready);
endinterface

// ===== hdl/mt_dpath.sv =====
// Datapath of the MT19937 generator: the 624-word state memory, the seeding
// multiplier, the twist logic, the tempering and the output register.
// Depends on mt_pkg.
`timescale 1ns / 1ps

module mt_dpath
    import mt_pkg::*;
(
    input  logic        i_clk,
    input  t_dp_cmd     i_cmd,
    input  logic [31:0] i_seed,
    output t_dp_status  o_status,
    output logic [31:0] o_word
);

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] t;
        t = x ^ (x >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    logic [31:0] r_mem [STATE_WORDS];

    logic [31:0]      r_prev;
    logic [31:0]      r_prod;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_pos;
    logic             r_cur_msb;
    logic [31:0]      r_rd_a;
    logic [31:0]      r_rd_b;
    logic [31:0]      r_out_word;

    logic [31:0]      n_prev;
    logic [31:0]      seed_sel;
    logic [31:0]      twisted;
    logic [31:0]      mix;
    logic [IDX_W:0]   far_sum;
    logic [IDX_W-1:0] far_addr;
    logic [IDX_W-1:0] next_addr;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_data;
    logic             wr_en;
    logic             rd_en;

    always_comb begin
        seed_sel = i_cmd.use_default ? DEFAULT_SEED : i_seed;
        n_prev   = r_prod + {{(32 - IDX_W){1'b0}}, r_idx};
        mix      = {r_cur_msb, r_rd_a[30:0]};
        twisted  = r_rd_b ^ (mix >> 1) ^ (mix[0] ? TWIST_MATRIX : 32'd0);

        far_sum  = {1'b0, r_idx} + (IDX_W + 1)'(TWIST_OFFSET);
        if (far_sum >= (IDX_W + 1)'(STATE_WORDS)) begin
            far_addr = IDX_W'(far_sum - (IDX_W + 1)'(STATE_WORDS));
        end else begin
            far_addr = far_sum[IDX_W-1:0];
        end
        next_addr = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;

        if (i_cmd.draw_read) begin
            rd_addr_a = r_pos;
        end else if (i_cmd.tw_read) begin
            rd_addr_a = next_addr;
        end else begin
            rd_addr_a = '0;
        end
        rd_en = i_cmd.tw_prime | i_cmd.tw_read | i_cmd.draw_read;

        wr_en   = i_cmd.seed_start | i_cmd.seed_add | i_cmd.tw_write;
        wr_addr = i_cmd.seed_start ? '0 : r_idx;
        if (i_cmd.seed_start) begin
            wr_data = seed_sel;
        end else if (i_cmd.seed_add) begin
            wr_data = n_prev;
        end else begin
            wr_data = twisted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[far_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_start) begin
            r_prev <= seed_sel;
            r_idx  <= IDX_W'(1);
        end
        if (i_cmd.seed_mul) begin
            r_prod <= SEED_MULT * (r_prev ^ (r_prev >> 30));
        end
        if (i_cmd.seed_add) begin
            r_prev <= n_prev;
            r_idx  <= r_idx + 1'b1;
            if (r_idx == LAST_IDX) begin
                r_pos <= POS_END;
            end
        end
        if (i_cmd.tw_prime) begin
            r_idx <= '0;
        end
        if (i_cmd.tw_read) begin
            r_cur_msb <= r_rd_a[31];
        end
        if (i_cmd.tw_write) begin
            r_idx <= r_idx + 1'b1;
            if (r_idx == LAST_IDX) begin
                r_pos <= '0;
            end
        end
        if (i_cmd.draw_read) begin
            r_pos <= r_pos + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_word <= temper(r_rd_a);
        end
    end

    assign o_status.idx_last = (r_idx == LAST_IDX);
    assign o_status.pos_end  = (r_pos == POS_END);
    assign o_word            = r_out_word;

endmodule

// ===== hdl/mt_ctrl.sv =====
// Controller of the MT19937 generator: sequences seeding, twisting and draws,
// and owns the input and output handshakes. Depends on mt_pkg.
`timescale 1ns / 1ps

module mt_ctrl
    import mt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_op,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_acc;
    logic   out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign out_free   = ~r_out_valid | i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:      n_state = S_SEED_MUL;
            S_SEED_MUL:  n_state = S_SEED_ADD;
            S_SEED_ADD:  n_state = i_status.idx_last ? S_IDLE : S_SEED_MUL;
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_op) begin
                        n_state = S_SEED_MUL;
                    end else if (i_status.pos_end) begin
                        n_state = S_TW_PRIME;
                    end else begin
                        n_state = S_DRAW_READ;
                    end
                end
            end
            S_TW_PRIME:  n_state = S_TW_READ;
            S_TW_READ:   n_state = S_TW_WRITE;
            S_TW_WRITE:  n_state = i_status.idx_last ? S_DRAW_READ : S_TW_READ;
            S_DRAW_READ: n_state = S_DRAW_LOAD;
            S_DRAW_LOAD: n_state = out_free ? S_IDLE : S_DRAW_LOAD;
            default:     n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.seed_start  = 1'b1;
                o_cmd.use_default = 1'b1;
            end
            S_SEED_MUL:  o_cmd.seed_mul   = 1'b1;
            S_SEED_ADD:  o_cmd.seed_add   = 1'b1;
            S_IDLE:      o_cmd.seed_start = in_acc & i_in_op;
            S_TW_PRIME:  o_cmd.tw_prime   = 1'b1;
            S_TW_READ:   o_cmd.tw_read    = 1'b1;
            S_TW_WRITE:  o_cmd.tw_write   = 1'b1;
            S_DRAW_READ: o_cmd.draw_read  = 1'b1;
            S_DRAW_LOAD: o_cmd.out_load   = out_free;
            default:     o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/mt19937_random_generator.sv =====
// MT19937 pseudo-random word generator, top level. Depends on mt_pkg,
// mt_in_if, mt_out_if, mt_ctrl and mt_dpath.
//
// Usage: i_cmd carries one transaction per request. With operation = 0 the
// block returns the next tempered 32-bit word on o_rsp; with operation = 1 it
// refills the 624-word state from seed_value and returns nothing.
// i_cmd.ready is high only while the controller is idle; one transaction is
// processed at a time.
// A draw passes through S_DRAW_READ and then S_DRAW_LOAD, which loads the
// word, raises o_rsp.valid and returns to idle. When all 624 words have
// been used, the draw first twists the state: a prime state, then a read
// and a write state per word, since each word needs a read and a write on
// the single-write state memory. A reseed alternates a multiply and an add
// state for each of the other 623 words, set by the registered multiplier
// of the seeding recurrence. After reset the block seeds itself with 5489,
// during which i_cmd.ready is low. o_rsp is registered: the next
// transaction is accepted while a word waits, and a stalled receiver only
// holds a later draw in S_DRAW_LOAD until the output register frees.
`timescale 1ns / 1ps

module mt19937_random_generator
    import mt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    mt_in_if.sink    i_cmd,
    mt_out_if.source o_rsp
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    mt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_in_op     (i_cmd.operation),
        .i_out_ready (o_rsp.ready),
        .i_status    (dp_status),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (dp_cmd)
    );

    mt_dpath u_dpath (
        .i_clk    (i_clk),
        .i_cmd    (dp_cmd),
        .i_seed   (i_cmd.seed_value),
        .o_status (dp_status),
        .o_word   (o_rsp.random_word)
    );

`ifndef SYNTHESIS
    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ready |-> !(dp_cmd.seed_add || dp_cmd.tw_write || dp_cmd.draw_read))
        else $error("input accepted while the datapath is busy");

    a_draw_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.draw_read |-> !dp_status.pos_end)
        else $error("draw read past the end of the state");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(dp_cmd.out_load))
        else $error("output valid without a loaded word");
`endif

endmodule

// ===== sim/mt19937_random_generator_test.sv =====
// Self-checking testbench for mt19937_random_generator: a queued command driver,
// a response monitor and a software twister that predicts every tempered word.
// Depends on mt_pkg, mt_in_if, mt_out_if and the generator RTL.
`timescale 1ns / 1ps

module mt19937_random_generator_test;
    import mt_pkg::*;

    localparam logic        OP_DRAW      = 1'b0;
    localparam logic        OP_RESEED    = 1'b1;
    localparam logic [31:0] UPPER_MASK   = 32'h8000_0000;
    localparam logic [31:0] LOWER_MASK   = 32'h7fff_ffff;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          SETTLE_TICKS = 16;
    localparam int          ITEM_COUNT   = 1550;

    typedef struct {
        logic        op;
        logic [31:0] seed;
        bit          drain;
    } t_cmd_item;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG} t_stall_mode;

    logic i_clk;
    logic i_rst_n;

    mt_in_if  cmd_if ();
    mt_out_if rsp_if ();

    mt19937_random_generator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    logic [31:0] twister_store [STATE_WORDS];
    int unsigned store_pos;
    logic [31:0] expected_words [$];
    t_cmd_item   pending_cmds [$];
    t_cmd_item   cur_cmd;

    int unsigned error_count;
    int unsigned words_checked;
    int unsigned draws_applied;
    int unsigned reseeds_applied;
    int unsigned twist_count;
    int unsigned drain_count;
    int unsigned cycle_count;
    int unsigned gap_left;
    int unsigned burst_left;
    int unsigned mode_left;
    t_stall_mode stall_mode;

    function automatic void reseed_store(input logic [31:0] seed);
        logic [31:0] prev;
        prev = seed;
        twister_store[0] = seed;
        for (int i = 1; i < STATE_WORDS; i++) begin
            prev = SEED_MULT * (prev ^ (prev >> 30)) + 32'(i);
            twister_store[i] = prev;
        end
        store_pos = STATE_WORDS;
    endfunction

    function automatic void twist_store();
        logic [31:0] y;
        logic [31:0] v;
        for (int i = 0; i < STATE_WORDS; i++) begin
            y = (twister_store[i] & UPPER_MASK)
              | (twister_store[(i + 1) % STATE_WORDS] & LOWER_MASK);
            v = twister_store[(i + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1);
            if (y[0]) begin
                v = v ^ TWIST_MATRIX;
            end
            twister_store[i] = v;
        end
        store_pos = 0;
        twist_count++;
    endfunction

    function automatic logic [31:0] temper_word(input logic [31:0] raw);
        logic [31:0] x;
        x = raw;
        x = x ^ (x >> 11);
        x = x ^ ((x << 7) & TEMPER_B);
        x = x ^ ((x << 15) & TEMPER_C);
        x = x ^ (x >> 18);
        return x;
    endfunction

    // Advances the predicted generator by one accepted transaction.
    function automatic void apply_command(input t_cmd_item item);
        if (item.op == OP_RESEED) begin
            reseed_store(item.seed);
            reseeds_applied++;
        end else begin
            if (store_pos >= STATE_WORDS) begin
                twist_store();
            end
            expected_words.push_back(temper_word(twister_store[store_pos]));
            store_pos++;
            draws_applied++;
        end
    endfunction

    function automatic logic [31:0] random_seed();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_cmd(input logic op, input logic [31:0] seed, input bit drain);
        t_cmd_item item;
        item.op    = op;
        item.seed  = seed;
        item.drain = drain;
        pending_cmds.push_back(item);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words outstanding.",
                     cycle_count, expected_words.size());
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : drive_cmd
        logic next_valid;
        if (!i_rst_n) begin
            cmd_if.valid      <= 1'b0;
            cmd_if.operation  <= OP_DRAW;
            cmd_if.seed_value <= '0;
            gap_left   = 0;
            burst_left = 0;
        end else begin
            next_valid = cmd_if.valid;
            if (cmd_if.valid && cmd_if.ready) begin
                apply_command(cur_cmd);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_cmds.size() != 0
                             && !(pending_cmds[0].drain && expected_words.size() != 0)) begin
                    cur_cmd = pending_cmds.pop_front();
                    if (cur_cmd.drain) begin
                        drain_count++;
                    end
                    next_valid = 1'b1;
                    cmd_if.operation  <= cur_cmd.op;
                    cmd_if.seed_value <= cur_cmd.seed;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25)
                                                                 : $urandom_range(1, 6);
                    end
                end
            end
            cmd_if.valid <= next_valid;
        end
    end

    always @(posedge i_clk) begin : check_rsp
        logic [31:0] want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_mode = RX_OPEN;
            mode_left  = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_words.size() == 0) begin
                    error_count++;
                    $display("%0t: word with no draw pending: expected none, actual %h",
                             $time, rsp_if.random_word);
                end else begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (rsp_if.random_word !== want) begin
                        error_count++;
                        $display("%0t: random_word mismatch: expected %h, actual %h",
                                 $time, want, rsp_if.random_word);
                    end
                end
            end
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 300);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                RX_OPEN:     rsp_if.ready <= 1'b1;
                RX_RANDOM:   rsp_if.ready <= ($urandom_range(0, 2) != 0);
                RX_PERIODIC: rsp_if.ready <= (mode_left % 4 != 0);
                default:     rsp_if.ready <= (mode_left % 10 >= 7);
            endcase
        end
    end

    initial begin : stimulus
        int unsigned draws;
        int unsigned long_runs;
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.operation  = OP_DRAW;
        cmd_if.seed_value = '0;
        rsp_if.ready      = 1'b0;
        reseed_store(DEFAULT_SEED);

        // The default stream comes first, then the edge seeds.
        queue_cmd(OP_DRAW, 32'h0000_0000, 1'b0);
        queue_cmd(OP_DRAW, 32'hffff_ffff, 1'b0);
        queue_cmd(OP_DRAW, 32'h8000_0000, 1'b0);
        queue_cmd(OP_RESEED, 32'h0000_0000, 1'b0);
        queue_cmd(OP_DRAW, 32'hffff_ffff, 1'b0);
        queue_cmd(OP_DRAW, 32'h0000_0000, 1'b0);
        queue_cmd(OP_RESEED, 32'hffff_ffff, 1'b0);
        queue_cmd(OP_DRAW, 32'h5555_5555, 1'b0);
        queue_cmd(OP_RESEED, 32'h8000_0000, 1'b0);
        queue_cmd(OP_DRAW, 32'haaaa_aaaa, 1'b0);
        queue_cmd(OP_RESEED, 32'h0000_0001, 1'b0);
        queue_cmd(OP_DRAW, 32'h0000_0000, 1'b0);
        queue_cmd(OP_RESEED, 32'haaaa_aaaa, 1'b1);
        queue_cmd(OP_DRAW, 32'h0000_0000, 1'b0);
        queue_cmd(OP_RESEED, 32'h5555_5555, 1'b0);
        queue_cmd(OP_DRAW, 32'hffff_ffff, 1'b0);
        queue_cmd(OP_RESEED, 32'h0000_1571, 1'b0);
        queue_cmd(OP_RESEED, 32'h7fff_ffff, 1'b0);
        queue_cmd(OP_DRAW, 32'h0000_0000, 1'b0);
        queue_cmd(OP_DRAW, 32'hffff_ffff, 1'b0);

        // One long run crosses a full twist without a reseed.
        queue_cmd(OP_DRAW, random_seed(), 1'b1);
        repeat (700) queue_cmd(OP_DRAW, random_seed(), 1'b0);

        long_runs = 0;
        while (pending_cmds.size() < ITEM_COUNT) begin
            queue_cmd(OP_RESEED, random_seed(), $urandom_range(0, 9) == 0);
            case ($urandom_range(0, 19))
                0: draws = 0;
                1: begin
                    draws = (long_runs == 0) ? $urandom_range(620, 660) : $urandom_range(1, 40);
                    long_runs++;
                end
                default: draws = $urandom_range(1, 40);
            endcase
            if (draws > ITEM_COUNT - pending_cmds.size()) begin
                draws = ITEM_COUNT - pending_cmds.size();
            end
            repeat (draws) queue_cmd(OP_DRAW, random_seed(), 1'b0);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || cmd_if.valid || expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("Run covered %0d draws and %0d reseeds, %0d full twists and %0d drain pauses.",
                 draws_applied, reseeds_applied, twist_count, drain_count);
        $display("%0d words compared, %0d errors.", words_checked, error_count);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mt_pkg.sv
hdl/mt_in_if.sv
hdl/mt_out_if.sv
hdl/mt_dpath.sv
hdl/mt_ctrl.sv
hdl/mt19937_random_generator.sv
sim/mt19937_random_generator_test.sv
